@@ sv/k_permutation_enumerator_core_defines.svh @@
// Assertion macros used by the k-permutation enumerator datapath.
`ifndef K_PERMUTATION_ENUMERATOR_CORE_DEFINES_SVH
`define K_PERMUTATION_ENUMERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define KPE_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define KPE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/kpe_pkg.sv @@
// Shared types and constants for the k-permutation enumerator.
package kpe_pkg;

   localparam int LETTER_W    = 4;
   localparam int CFG_W       = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int ARR_W       = 64;
   localparam int REQ_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_LETTERS   = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POSITIONS = 4'd1;

   localparam logic [CFG_W-1:0] RESET_LETTERS   = 5'd4;
   localparam logic [CFG_W-1:0] RESET_POSITIONS = 5'd4;

   typedef struct packed {
      logic start;
      logic fill_step;
      logic back_init;
      logic back_step;
      logic set_finished;
      logic load_result;
      logic load_exhausted;
   } kpe_cmd_type;

   typedef struct packed {
      logic started;
      logic finished;
      logic bad_size;
      logic at_end;
      logic found;
      logic depth_zero;
      logic out_free;
   } kpe_status_type;

endpackage

@@ sv/k_permutation_enumerator_core.sv @@
// Restart: FILL places one position per cycle, then EMIT loads the result register once it is free.
// Next: the search unpicks and refills one position per cycle.
// Exhausted results are loaded from EXH, reached at once when already known or when the search runs out.
// One request is in flight; a stalled result beat holds the next result in EMIT or EXH until it drains.
// Configuration writes are always ready and must arrive while no request is in flight.
// Synchronous reset sets letters_in_use and positions to 4 and abandons any enumeration.
module k_permutation_enumerator_core #(
   parameter int MAX_LETTERS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [kpe_pkg::REQ_DATA_W-1:0]      req_tdata,   // [0] restart, [7:1] zero
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kpe_pkg::ARR_W-1:0]           rsp_tdata,   // [63:0] arrangement
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,   // [0] exhausted
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kpe_pkg::CFG_W-1:0]           csr_data
);

   kpe_pkg::kpe_cmd_type    cmd;
   kpe_pkg::kpe_status_type status;

   assign csr_ready = 1'b1;

   kpe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .restart    (req_tdata[0]),
      .status     (status),
      .cmd        (cmd)
   );

   kpe_datapath #(
      .MAX_LETTERS (MAX_LETTERS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sv/kpe_ctrl.sv @@
// Sequencing state machine for the k-permutation enumerator.
module kpe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   restart,
   input  kpe_pkg::kpe_status_type status,
   output kpe_pkg::kpe_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_FILL = 3'd1;
   localparam logic [2:0] ST_BACK = 3'd2;
   localparam logic [2:0] ST_EMIT = 3'd3;
   localparam logic [2:0] ST_EXH  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (restart || !status.started) begin
                  cmd.start = 1'b1;
                  state_in  = status.bad_size ? ST_EXH : ST_FILL;
               end else if (status.finished) begin
                  state_in = ST_EXH;
               end else begin
                  cmd.back_init = 1'b1;
                  state_in      = ST_BACK;
               end
            end
         end
         ST_FILL: begin
            if (status.at_end) begin
               state_in = ST_EMIT;
            end else begin
               cmd.fill_step = 1'b1;
            end
         end
         ST_BACK: begin
            cmd.back_step = 1'b1;
            if (status.found) begin
               state_in = ST_FILL;
            end else if (status.depth_zero) begin
               cmd.set_finished = 1'b1;
               state_in         = ST_EXH;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_EXH: begin
            if (status.out_free) begin
               cmd.load_exhausted = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/kpe_datapath.sv @@
// Choice stack, letter mask, depth pointer, configuration and result register.
`include "k_permutation_enumerator_core_defines.svh"

module kpe_datapath #(
   parameter int MAX_LETTERS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [kpe_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [kpe_pkg::CFG_W-1:0]           csr_data,
   input  kpe_pkg::kpe_cmd_type                cmd,
   output kpe_pkg::kpe_status_type             status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [kpe_pkg::ARR_W-1:0]           rsp_tdata,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser
);

   localparam int DW = $clog2(MAX_LETTERS);
   localparam int LW = kpe_pkg::LETTER_W;
   localparam int CW = kpe_pkg::CFG_W;

   logic [CW-1:0]          letters_ff, letters_in;
   logic [CW-1:0]          positions_ff, positions_in;
   logic                   started_ff, started_in;
   logic                   finished_ff, finished_in;
   logic [MAX_LETTERS-1:0] mask_ff, mask_in;
   logic [CW-1:0]          depth_ff, depth_in;
   logic [LW-1:0]          stack_ff [MAX_LETTERS];
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [kpe_pkg::ARR_W-1:0] rsp_arr_ff, rsp_arr_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   rsp_exh_ff, rsp_exh_in;

   logic [CW-1:0]          m_eff;
   logic [LW-1:0]          cur_letter;
   logic [MAX_LETTERS-1:0] freed_mask;
   logic [MAX_LETTERS-1:0] base_mask;
   logic [MAX_LETTERS-1:0] cand;
   logic [LW-1:0]          pick;
   logic                   found;
   logic                   stack_we;
   logic [kpe_pkg::ARR_W-1:0] asm_arr;
   logic                   asm_last;

   assign m_eff = (letters_ff > CW'(MAX_LETTERS)) ? CW'(MAX_LETTERS) : letters_ff;
   assign cur_letter = stack_ff[depth_ff[DW-1:0]];
   assign freed_mask = mask_ff & ~(MAX_LETTERS'(1) << cur_letter);
   assign base_mask  = cmd.back_step ? freed_mask : mask_ff;

   always_comb begin
      pick = '0;
      for (int i = 0; i < MAX_LETTERS; i++) begin
         cand[i] = !base_mask[i] && (CW'(i) < m_eff) &&
                   (!cmd.back_step || (LW'(i) > cur_letter));
      end
      for (int i = MAX_LETTERS - 1; i >= 0; i--) begin
         if (cand[i]) begin
            pick = LW'(i);
         end
      end
      found = |cand;
   end

   always_comb begin
      asm_arr  = '0;
      asm_last = 1'b1;
      for (int i = 0; i < MAX_LETTERS; i++) begin
         if (CW'(i) < positions_ff) begin
            asm_arr[i*LW +: LW] = stack_ff[i];
            if ({1'b0, stack_ff[i]} != (m_eff - CW'(i + 1))) begin
               asm_last = 1'b0;
            end
         end
      end
   end

   assign stack_we = cmd.fill_step || (cmd.back_step && found);

   always_comb begin
      letters_in   = letters_ff;
      positions_in = positions_ff;
      started_in   = started_ff;
      finished_in  = finished_ff;
      mask_in      = mask_ff;
      depth_in     = depth_ff;
      if (csr_valid) begin
         if (csr_index == kpe_pkg::REG_LETTERS) begin
            letters_in  = csr_data;
            started_in  = 1'b0;
            finished_in = 1'b0;
         end else if (csr_index == kpe_pkg::REG_POSITIONS) begin
            positions_in = csr_data;
            started_in   = 1'b0;
            finished_in  = 1'b0;
         end
      end
      if (cmd.start) begin
         started_in  = 1'b1;
         finished_in = status.bad_size;
         mask_in     = '0;
         depth_in    = '0;
      end
      if (cmd.set_finished) begin
         finished_in = 1'b1;
      end
      if (cmd.back_init) begin
         depth_in = positions_ff - CW'(1);
      end
      if (cmd.fill_step) begin
         mask_in  = mask_ff | (MAX_LETTERS'(1) << pick);
         depth_in = depth_ff + CW'(1);
      end
      if (cmd.back_step) begin
         if (found) begin
            mask_in  = freed_mask | (MAX_LETTERS'(1) << pick);
            depth_in = depth_ff + CW'(1);
         end else begin
            mask_in = freed_mask;
            if (depth_ff != '0) begin
               depth_in = depth_ff - CW'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_arr_in   = rsp_arr_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_exh_in   = rsp_exh_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
         rsp_arr_in   = asm_arr;
         rsp_last_in  = asm_last;
         rsp_exh_in   = 1'b0;
      end else if (cmd.load_exhausted) begin
         rsp_valid_in = 1'b1;
         rsp_arr_in   = '0;
         rsp_last_in  = 1'b0;
         rsp_exh_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letters_ff   <= kpe_pkg::RESET_LETTERS;
         positions_ff <= kpe_pkg::RESET_POSITIONS;
         started_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         mask_ff      <= '0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         letters_ff   <= letters_in;
         positions_ff <= positions_in;
         started_ff   <= started_in;
         finished_ff  <= finished_in;
         mask_ff      <= mask_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_arr_ff  <= rsp_arr_in;
      rsp_last_ff <= rsp_last_in;
      rsp_exh_ff  <= rsp_exh_in;
      if (stack_we) begin
         stack_ff[depth_ff[DW-1:0]] <= pick;
      end
   end

   assign status.started    = started_ff;
   assign status.finished   = finished_ff;
   assign status.bad_size   = (positions_ff == '0) || (positions_ff > m_eff);
   assign status.at_end     = (depth_ff == positions_ff);
   assign status.found      = found;
   assign status.depth_zero = (depth_ff == '0);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_arr_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_exh_ff;

   `KPE_ASSERT_IMPLY(a_fill_below_n, cmd.fill_step, depth_ff < positions_ff, "fill past end")
   `KPE_ASSERT_IMPLY(a_mask_depth, cmd.fill_step, $countones(mask_ff) == int'(depth_ff), "mask off")
   `KPE_ASSERT_IMPLY(a_result_complete, cmd.load_result, depth_ff == positions_ff, "early load")
   `KPE_ASSERT_NEXT(a_exh_beat, cmd.load_exhausted, rsp_tvalid && rsp_tuser, "no exhausted beat")
   `KPE_ASSERT_NEXT(a_exh_data, cmd.load_exhausted, (rsp_tdata == '0) && !rsp_tlast, "stale data")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the k-permutation enumerator core.
`timescale 1ns / 100ps

module testbench;

   localparam int ARR_W       = kpe_pkg::ARR_W;
   localparam int REQ_DATA_W  = kpe_pkg::REQ_DATA_W;
   localparam int CSR_INDEX_W = kpe_pkg::CSR_INDEX_W;
   localparam int CFG_W       = kpe_pkg::CFG_W;
   localparam int LETTER_W    = kpe_pkg::LETTER_W;

   localparam int LONG_HOLD = 300;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEM_TARGET = 1200;

   typedef struct packed {
      logic [ARR_W-1:0] arrangement;
      logic             is_last;
      logic             exhausted;
   } arrangement_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [ARR_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_data = '0;

   bit [CFG_W-1:0] letters_cfg = kpe_pkg::RESET_LETTERS;
   bit [CFG_W-1:0] positions_cfg = kpe_pkg::RESET_POSITIONS;
   bit [LETTER_W-1:0] chosen [16];
   bit [15:0] taken;
   bit enum_started;
   bit enum_done;

   bit pending_restarts [$];
   arrangement_type arrangements_due [$];
   int requests_sent;
   int requests_taken;
   int req_gap;
   int rsp_stall;
   int holds_asked;
   int holds_served;
   bit no_idle;

   int mismatches;
   int results_checked;
   int lasts_seen;
   int exhausted_seen;
   int settings_tried;

   k_permutation_enumerator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int gap_length();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   function automatic void fill_positions(int first, int n, int m);
      for (int d = first; d < n && d < 16; d++) begin
         for (int l = 0; l < m; l++) begin
            if (!taken[l]) begin
               chosen[d] = LETTER_W'(l);
               taken[l] = 1'b1;
               break;
            end
         end
      end
   endfunction

   function automatic bit step_forward(int n, int m);
      int d;
      int l;
      d = n - 1;
      while (d >= 0) begin
         l = chosen[d];
         taken[l] = 1'b0;
         for (int c = l + 1; c < m; c++) begin
            if (!taken[c]) begin
               chosen[d] = LETTER_W'(c);
               taken[c] = 1'b1;
               fill_positions(d + 1, n, m);
               return 1'b1;
            end
         end
         d--;
      end
      return 1'b0;
   endfunction

   function automatic arrangement_type next_arrangement(bit restart);
      arrangement_type r;
      int m;
      int n;
      bit ok;
      m = (letters_cfg > 16) ? 16 : letters_cfg;
      n = positions_cfg;
      r = '0;
      if (restart || !enum_started) begin
         enum_started = 1'b1;
         taken = '0;
         if (n == 0 || n > m) begin
            enum_done = 1'b1;
            ok = 1'b0;
         end else begin
            enum_done = 1'b0;
            fill_positions(0, n, m);
            ok = 1'b1;
         end
      end else if (enum_done) begin
         ok = 1'b0;
      end else begin
         ok = step_forward(n, m);
         if (!ok) enum_done = 1'b1;
      end
      if (ok) begin
         r.is_last = 1'b1;
         for (int i = 0; i < n; i++) begin
            r.arrangement[4*i +: 4] = chosen[i];
            if (chosen[i] != m - 1 - i) r.is_last = 1'b0;
         end
      end else begin
         r.exhausted = 1'b1;
      end
      return r;
   endfunction

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || requests_taken == requests_sent) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap--;
         end else if (pending_restarts.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {{(REQ_DATA_W-1){1'b0}}, pending_restarts.pop_front()};
            requests_sent++;
            req_gap = no_idle ? 0 : gap_length();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         rsp_stall = LONG_HOLD - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_stall = no_idle ? 0 : gap_length();
         rsp_tready <= (rsp_stall == 0);
         if (rsp_stall > 0) rsp_stall--;
      end
   end

   always @(posedge clock) begin
      arrangement_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            arrangements_due.push_back(next_arrangement(req_tdata[0]));
            requests_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (arrangements_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, expected none, got %h", $time,
                        rsp_tdata);
            end else begin
               want = arrangements_due.pop_front();
               results_checked++;
               if (want.is_last) lasts_seen++;
               if (want.exhausted) exhausted_seen++;
               if (rsp_tdata !== want.arrangement) begin
                  mismatches++;
                  $display("%0t: arrangement expected %h, got %h", $time,
                           want.arrangement, rsp_tdata);
               end
               if (rsp_tlast !== want.is_last) begin
                  mismatches++;
                  $display("%0t: last flag expected %b, got %b", $time,
                           want.is_last, rsp_tlast);
               end
               if (rsp_tuser !== want.exhausted) begin
                  mismatches++;
                  $display("%0t: exhausted flag expected %b, got %b", $time,
                           want.exhausted, rsp_tuser);
               end
            end
         end
      end
   end

   task automatic wait_idle();
      while (pending_restarts.size() != 0 || requests_sent != requests_taken ||
             arrangements_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_INDEX_W-1:0] idx,
                                 logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == kpe_pkg::REG_LETTERS) begin
         letters_cfg = value;
         enum_started = 1'b0;
         enum_done = 1'b0;
      end else if (idx == kpe_pkg::REG_POSITIONS) begin
         positions_cfg = value;
         enum_started = 1'b0;
         enum_done = 1'b0;
      end
      settings_tried++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int items_planned;
      int phase;
      int kind;
      int m;
      int n;
      int m_eff;
      int total;
      int run_len;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      pending_restarts = '{1'b0, 1'b1, 1'b0, 1'b0};
      wait_idle();
      write_register(kpe_pkg::REG_LETTERS, 5'd3);
      write_register(kpe_pkg::REG_POSITIONS, 5'd3);
      pending_restarts = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      wait_idle();
      write_register(kpe_pkg::REG_POSITIONS, 5'd0);
      pending_restarts.push_back(1'b0);
      wait_idle();
      write_register(kpe_pkg::REG_POSITIONS, 5'd5);
      pending_restarts.push_back(1'b1);
      wait_idle();
      write_register(kpe_pkg::REG_LETTERS, 5'd31);
      write_register(kpe_pkg::REG_POSITIONS, 5'd16);
      pending_restarts = '{1'b1, 1'b0, 1'b0};
      wait_idle();
      write_register(kpe_pkg::REG_LETTERS, 5'd16);
      write_register(kpe_pkg::REG_POSITIONS, 5'd2);
      pending_restarts = '{1'b1, 1'b0};
      wait_idle();
      write_register(4'hF, 5'h1F);
      pending_restarts.push_back(1'b0);
      wait_idle();
      write_register(kpe_pkg::REG_LETTERS, 5'd16);
      pending_restarts.push_back(1'b0);
      wait_idle();
      write_register(kpe_pkg::REG_LETTERS, 5'd1);
      write_register(kpe_pkg::REG_POSITIONS, 5'd1);
      pending_restarts = '{1'b0, 1'b0};
      items_planned = 24;

      phase = 0;
      while (items_planned < ITEM_TARGET) begin
         wait_idle();
         no_idle = ($urandom_range(4) == 0);
         kind = $urandom_range(9);
         if (kind < 6) begin
            m = $urandom_range(6, 1);
            n = $urandom_range(m, 1);
         end else if (kind < 9) begin
            m = $urandom_range(31, 7);
            n = $urandom_range((m > 16) ? 16 : m, 1);
         end else begin
            m = $urandom_range(31);
            n = $urandom_range(31);
         end
         if ($urandom_range(3) == 0)
            write_register(CSR_INDEX_W'($urandom_range(15, kpe_pkg::REG_POSITIONS + 1)),
                           CFG_W'($urandom_range(31)));
         if ($urandom_range(1)) begin
            write_register(kpe_pkg::REG_LETTERS, CFG_W'(m));
            write_register(kpe_pkg::REG_POSITIONS, CFG_W'(n));
         end else begin
            write_register(kpe_pkg::REG_POSITIONS, CFG_W'(n));
            write_register(kpe_pkg::REG_LETTERS, CFG_W'(m));
         end
         m_eff = (m > 16) ? 16 : m;
         total = (n == 0 || n > m_eff) ? 0 : 1;
         for (int i = 0; i < n && total > 0 && total < 1000; i++) total *= m_eff - i;
         run_len = (total <= 80) ? total + $urandom_range(3, 1) : $urandom_range(60, 15);
         if (phase % 12 == 5) holds_asked++;
         for (int k = 0; k < run_len; k++)
            pending_restarts.push_back((k == 0) ? 1'($urandom_range(1))
                                                : ($urandom_range(39) == 0));
         items_planned += run_len;
         phase++;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results across %0d register writes, with %0d long receiver holds.",
               results_checked, settings_tried, holds_served);
      $display("Runs reached their final arrangement %0d times; %0d requests found none left.",
               lasts_seen, exhausted_seen);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
